### hdl/msil_pkg.sv
package msil_pkg;

   // list geometry
   localparam int DEPTH       = 16;
   localparam int PART_WIDTH  = 16;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int MAG_W       = 2 * PART_WIDTH;

   // fixed field widths on the channels
   localparam int PART_FIELD_W = 16;
   localparam int POS_FIELD_W  = 5;
   localparam int CNT_FIELD_W  = 5;
   localparam int STATUS_W     = 2;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      ACT_INSERT = 1'b0,
      ACT_DUMP   = 1'b1
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED = 2'd0,
      ST_FULL     = 2'd1,
      ST_DUMPED   = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   typedef logic signed [PART_WIDTH-1:0] part_type;
   typedef logic [MAG_W-1:0]             mag_type;

   typedef struct packed {
      action_type action;
      part_type   re;
      part_type   im;
      mag_type    mag;
   } cmd_type;

   typedef struct packed {
      logic signed [PART_FIELD_W-1:0] out_real;
      logic signed [PART_FIELD_W-1:0] out_imag;
      status_type                     status;
      logic [POS_FIELD_W-1:0]         position;
      logic [CNT_FIELD_W-1:0]         entry_count;
      logic                           last_of_run;
   } rsp_type;

endpackage

### hdl/msil_if.sv
interface msil_req_if import msil_pkg::*; ();
   logic                           valid;
   logic                           ready;
   logic                           action;
   logic signed [PART_FIELD_W-1:0] real_part;
   logic signed [PART_FIELD_W-1:0] imag_part;

   modport source (output valid, output action, output real_part, output imag_part,
                   input ready);
   modport sink   (input valid, input action, input real_part, input imag_part,
                   output ready);
endinterface

interface msil_rsp_if import msil_pkg::*; ();
   logic                           valid;
   logic                           ready;
   logic signed [PART_FIELD_W-1:0] out_real;
   logic signed [PART_FIELD_W-1:0] out_imag;
   logic [STATUS_W-1:0]            status;
   logic [POS_FIELD_W-1:0]         position;
   logic [CNT_FIELD_W-1:0]         entry_count;
   logic                           last_of_run;

   modport source (output valid, output out_real, output out_imag, output status,
                   output position, output entry_count, output last_of_run,
                   input ready);
   modport sink   (input valid, input out_real, input out_imag, input status,
                   input position, input entry_count, input last_of_run,
                   output ready);
endinterface

### hdl/magnitude_sorted_insert_list.sv
// sorted list of up to 16 complex values, ordered by ascending squared magnitude
// req_ch: valid/ready request channel; action insert puts the value in front of
//   the first entry with a strictly greater magnitude, action dump reads the list
// rsp_ch: valid/ready result channel; one result per insert (inserted or full),
//   one per stored entry on a dump (last_of_run on the final one), or a single
//   empty result when a dump finds no entries
// path: a request passes the square stage, the command queue and the cell row
//   with its output register before its result shows on rsp_ch
// throughput: one insert per cycle while the output register is free; a dump
//   holds the cell row until each stored entry has had its output register write
// reset: synchronous, clears the entry count, the queue, the square stage valid
//   and the output valid; the stored values and the output data are left as they are
// stall: the output register holds its result while rsp_ch.ready is low;
//   the 2-deep command queue and the square stage keep taking requests
//   until they are full, then req_ch.ready drops
module magnitude_sorted_insert_list import msil_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   msil_req_if.sink   req_ch,
   msil_rsp_if.source rsp_ch
);

   // front to queue
   logic    push_valid;
   logic    push_ready;
   cmd_type push_cmd;

   // queue to back
   logic    pop_valid;
   logic    pop_ready;
   cmd_type pop_cmd;

   // front: takes the request, squares both parts, forms the magnitude
   msil_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   // short queue lets the front keep going during a dump or an output stall
   msil_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   // back: cell row, dump sequencer and output register
   msil_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd),
      .rsp       (rsp_ch)
   );

endmodule

### hdl/msil_front.sv
module msil_front import msil_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   msil_req_if.sink req,
   output logic    push_valid,
   input  logic    push_ready,
   output cmd_type push_cmd
);

   logic                    stg_valid_ff, stg_valid_in;
   action_type              stg_action_ff, stg_action_in;
   part_type                stg_re_ff, stg_re_in;
   part_type                stg_im_ff, stg_im_in;
   mag_type                 sq_re_ff, sq_im_ff;
   logic signed [MAG_W-1:0] sq_re_in, sq_im_in;
   logic                    accept;

   assign req.ready = !stg_valid_ff || push_ready;
   assign accept    = req.valid && req.ready;

   always_comb begin
      stg_action_in = action_type'(req.action);
      stg_re_in     = PART_WIDTH'(req.real_part);
      stg_im_in     = PART_WIDTH'(req.imag_part);
      // squares in the full product width
      sq_re_in      = stg_re_in * stg_re_in;
      sq_im_in      = stg_im_in * stg_im_in;
      stg_valid_in  = accept || (stg_valid_ff && !push_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stg_action_ff <= stg_action_in;
         stg_re_ff     <= stg_re_in;
         stg_im_ff     <= stg_im_in;
         sq_re_ff      <= unsigned'(sq_re_in);
         sq_im_ff      <= unsigned'(sq_im_in);
      end
   end

   // each square is at most 2^(2w-2), so the sum fits
   assign push_valid      = stg_valid_ff;
   assign push_cmd.action = stg_action_ff;
   assign push_cmd.re     = stg_re_ff;
   assign push_cmd.im     = stg_im_ff;
   assign push_cmd.mag    = sq_re_ff + sq_im_ff;

endmodule

### hdl/msil_queue.sv
module msil_queue import msil_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   cmd_type                q_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] cnt_ff, cnt_in;
   logic                   push, pop;

   assign push_ready = cnt_ff != QUEUE_CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = cnt_ff != '0;
   assign pop_cmd    = q_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                     : wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                     : rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### hdl/msil_back.sv
module msil_back import msil_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      pop_valid,
   output logic      pop_ready,
   input  cmd_type   pop_cmd,
   msil_rsp_if.source rsp
);

   typedef enum logic {
      S_IDLE,
      S_DUMP
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   part_type          cell_re_ff  [DEPTH];
   part_type          cell_im_ff  [DEPTH];
   mag_type           cell_mag_ff [DEPTH];

   logic [DEPTH-1:0]  gt;
   logic [IDX_W-1:0]  ins_pos;
   logic              out_free, full, do_insert, dump_last;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign full      = count_ff == CNT_W'(DEPTH);
   assign pop_ready = (state_ff == S_IDLE) && out_free;
   assign do_insert = pop_valid && pop_ready && (pop_cmd.action == ACT_INSERT) && !full;
   assign dump_last = (CNT_W'(idx_ff) + CNT_W'(1)) == count_ff;

   // row of cells: each compares its magnitude and shifts on its own
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      assign gt[g] = (CNT_W'(g) < count_ff) && (cell_mag_ff[g] > pop_cmd.mag);

      if (g == 0) begin : g_head
         always_ff @(posedge clock) begin
            if (do_insert && ins_pos == '0) begin
               cell_re_ff[g]  <= pop_cmd.re;
               cell_im_ff[g]  <= pop_cmd.im;
               cell_mag_ff[g] <= pop_cmd.mag;
            end
         end
      end else begin : g_body
         always_ff @(posedge clock) begin
            if (do_insert) begin
               if (ins_pos == IDX_W'(g)) begin
                  cell_re_ff[g]  <= pop_cmd.re;
                  cell_im_ff[g]  <= pop_cmd.im;
                  cell_mag_ff[g] <= pop_cmd.mag;
               end else if (ins_pos < IDX_W'(g)) begin
                  cell_re_ff[g]  <= cell_re_ff[g-1];
                  cell_im_ff[g]  <= cell_im_ff[g-1];
                  cell_mag_ff[g] <= cell_mag_ff[g-1];
               end
            end
         end
      end
   end

   // first slot with a strictly greater magnitude, else the tail
   always_comb begin
      ins_pos = IDX_W'(count_ff);
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (gt[i]) begin
            ins_pos = IDX_W'(i);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_in       = rsp_ff;
      case (state_ff)
         S_IDLE: begin
            if (pop_valid && out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in.out_real      = '0;
               rsp_in.out_imag      = '0;
               rsp_in.position      = '0;
               rsp_in.entry_count   = CNT_FIELD_W'(count_ff);
               rsp_in.last_of_run   = 1'b1;
               if (pop_cmd.action == ACT_INSERT) begin
                  if (full) begin
                     rsp_in.status = ST_FULL;
                  end else begin
                     rsp_in.status      = ST_INSERTED;
                     rsp_in.position    = POS_FIELD_W'(ins_pos);
                     rsp_in.entry_count = CNT_FIELD_W'(count_ff + CNT_W'(1));
                     count_in           = count_ff + CNT_W'(1);
                  end
               end else if (count_ff == '0) begin
                  rsp_in.status = ST_EMPTY;
               end else begin
                  rsp_in.status      = ST_DUMPED;
                  rsp_in.out_real    = PART_FIELD_W'(unsigned'(cell_re_ff[0]));
                  rsp_in.out_imag    = PART_FIELD_W'(unsigned'(cell_im_ff[0]));
                  rsp_in.last_of_run = count_ff == CNT_W'(1);
                  if (count_ff != CNT_W'(1)) begin
                     state_in = S_DUMP;
                     idx_in   = IDX_W'(1);
                  end
               end
            end
         end
         S_DUMP: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = ST_DUMPED;
               rsp_in.out_real    = PART_FIELD_W'(unsigned'(cell_re_ff[idx_ff]));
               rsp_in.out_imag    = PART_FIELD_W'(unsigned'(cell_im_ff[idx_ff]));
               rsp_in.position    = POS_FIELD_W'(idx_ff);
               rsp_in.entry_count = CNT_FIELD_W'(count_ff);
               rsp_in.last_of_run = dump_last;
               if (dump_last) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.out_real    = rsp_ff.out_real;
   assign rsp.out_imag    = rsp_ff.out_imag;
   assign rsp.status      = rsp_ff.status;
   assign rsp.position    = rsp_ff.position;
   assign rsp.entry_count = rsp_ff.entry_count;
   assign rsp.last_of_run = rsp_ff.last_of_run;

endmodule

### hdl/msil_checker.sv
module msil_checker import msil_pkg::*; (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input logic [PART_FIELD_W-1:0] rsp_out_real,
   input logic [PART_FIELD_W-1:0] rsp_out_imag,
   input logic [STATUS_W-1:0]     rsp_status,
   input logic [POS_FIELD_W-1:0]  rsp_position,
   input logic [CNT_FIELD_W-1:0]  rsp_entry_count,
   input logic                    rsp_last_of_run
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_real)
         && $stable(rsp_out_imag) && $stable(rsp_status)
         && $stable(rsp_position) && $stable(rsp_entry_count)
         && $stable(rsp_last_of_run))
   else $error("result changed while stalled");

   // a dumped entry is marked last exactly at the end of the list
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_DUMPED |->
         (rsp_position < rsp_entry_count)
         && (rsp_last_of_run == (({1'b0, rsp_position} + 6'd1) == {1'b0, rsp_entry_count})))
   else $error("dump position or last flag wrong");

   // an insert lands inside the grown list
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_INSERTED |->
         rsp_last_of_run && rsp_entry_count != '0 && rsp_position < rsp_entry_count)
   else $error("insert result inconsistent");

   // empty dump reports no entries
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |->
         rsp_last_of_run && rsp_entry_count == '0)
   else $error("empty result inconsistent");

   // a dumped result that directly follows the end of a run starts at the head
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_of_run ##1 rsp_valid && rsp_status == ST_DUMPED
         |-> rsp_position == '0)
   else $error("dump run did not start at the head");

endmodule

bind magnitude_sorted_insert_list msil_checker u_msil_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_out_real    (rsp_ch.out_real),
   .rsp_out_imag    (rsp_ch.out_imag),
   .rsp_status      (rsp_ch.status),
   .rsp_position    (rsp_ch.position),
   .rsp_entry_count (rsp_ch.entry_count),
   .rsp_last_of_run (rsp_ch.last_of_run)
);

### tb/testbench.sv
module testbench;
   import msil_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // one request as the sender queues it
   typedef struct {
      action_type action;
      part_type   re;
      part_type   im;
   } list_request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   msil_req_if req_ch ();
   msil_rsp_if rsp_ch ();

   magnitude_sorted_insert_list dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   // requests waiting to go out, and results the list should still produce
   list_request_type pending_requests[$];
   rsp_type          expected_rsp[$];

   // shadow copy of the sorted list
   part_type shadow_re[DEPTH];
   part_type shadow_im[DEPTH];
   int       shadow_count = 0;

   // bookkeeping shared between driver, monitor and stimulus
   int req_offered     = 0;
   int req_transfers   = 0;
   int rsp_transfers   = 0;
   int mismatch_count  = 0;
   int sender_idle_pct = 0;
   int rsp_stall_pct   = 0;

   // long receiver hold-off, requested by the stimulus and counted by the receiver
   int holdoff_requests = 0;
   int holdoff_granted  = 0;
   int holdoff_left     = 0;

   // exact squared magnitude, wide enough for -32768 on both parts
   function automatic longint unsigned squared_magnitude(part_type re, part_type im);
      longint a;
      longint b;
      a = re;
      b = im;
      return longint'(a * a + b * b);
   endfunction

   function automatic rsp_type make_result(part_type re, part_type im, status_type st,
                                           int pos, int cnt, bit last);
      rsp_type r;
      r.out_real    = re;
      r.out_imag    = im;
      r.status      = st;
      r.position    = POS_FIELD_W'(pos);
      r.entry_count = CNT_FIELD_W'(cnt);
      r.last_of_run = last;
      return r;
   endfunction

   // work out the results of one accepted request and update the shadow list
   task automatic predict_list_op(list_request_type r);
      longint unsigned m;
      int pos;
      if (r.action == ACT_DUMP) begin
         // empty list gives a single marker result
         if (shadow_count == 0)
            expected_rsp.push_back(make_result('0, '0, ST_EMPTY, 0, 0, 1'b1));
         else
            for (int i = 0; i < shadow_count; i++)
               expected_rsp.push_back(make_result(shadow_re[i], shadow_im[i], ST_DUMPED, i,
                                                  shadow_count, i == shadow_count - 1));
      end else if (shadow_count >= DEPTH) begin
         // no free slot: value dropped, count unchanged
         expected_rsp.push_back(make_result('0, '0, ST_FULL, 0, shadow_count, 1'b1));
      end else begin
         m   = squared_magnitude(r.re, r.im);
         pos = shadow_count;
         // first entry strictly larger wins, so ties keep arrival order
         for (int i = 0; i < shadow_count; i++) begin
            if (squared_magnitude(shadow_re[i], shadow_im[i]) > m) begin
               pos = i;
               break;
            end
         end
         for (int i = shadow_count; i > pos; i--) begin
            shadow_re[i] = shadow_re[i-1];
            shadow_im[i] = shadow_im[i-1];
         end
         shadow_re[pos] = r.re;
         shadow_im[pos] = r.im;
         shadow_count++;
         expected_rsp.push_back(make_result('0, '0, ST_INSERTED, pos, shadow_count, 1'b1));
      end
   endtask

   // known values on every block input before the first falling edge
   initial begin
      req_ch.valid     = 1'b0;
      req_ch.action    = 1'b0;
      req_ch.real_part = '0;
      req_ch.imag_part = '0;
      rsp_ch.ready     = 1'b0;
   end

   // request driver: a request stays on the bus until its transfer, then the
   // next one may follow, after a random idle gap
   always @(negedge clock) begin : drive_requests
      list_request_type next_req;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (req_offered == req_transfers) begin
         if (pending_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            next_req = pending_requests.pop_front();
            req_offered++;
            req_ch.valid     <= 1'b1;
            req_ch.action    <= next_req.action;
            req_ch.real_part <= next_req.re;
            req_ch.imag_part <= next_req.im;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // result receiver: random stalls, plus an occasional long hold-off
   always @(negedge clock) begin : drive_rsp_ready
      if (holdoff_granted != holdoff_requests) begin
         holdoff_granted = holdoff_requests;
         holdoff_left    = 80;
      end
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // monitor: checks result transfers against the oldest expectation, then
   // feeds accepted requests to the predictor
   always @(posedge clock) begin : watch_channels
      rsp_type          want;
      list_request_type seen;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsp_transfers++;
         if (expected_rsp.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected re=%0d im=%0d st=%0d pos=%0d cnt=%0d last=%0d",
                     $realtime, rsp_ch.out_real, rsp_ch.out_imag, rsp_ch.status,
                     rsp_ch.position, rsp_ch.entry_count, rsp_ch.last_of_run);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_ch.out_real !== want.out_real || rsp_ch.out_imag !== want.out_imag ||
                rsp_ch.status !== want.status || rsp_ch.position !== want.position ||
                rsp_ch.entry_count !== want.entry_count ||
                rsp_ch.last_of_run !== want.last_of_run) begin
               mismatch_count++;
               $display("%0t: expected re=%0d im=%0d st=%0d pos=%0d cnt=%0d last=%0d",
                        $realtime, want.out_real, want.out_imag, want.status,
                        want.position, want.entry_count, want.last_of_run);
               $display("%0t:   actual re=%0d im=%0d st=%0d pos=%0d cnt=%0d last=%0d",
                        $realtime, rsp_ch.out_real, rsp_ch.out_imag, rsp_ch.status,
                        rsp_ch.position, rsp_ch.entry_count, rsp_ch.last_of_run);
            end
         end
      end
      if (!reset && req_ch.valid && req_ch.ready) begin
         seen.action = action_type'(req_ch.action);
         seen.re     = req_ch.real_part;
         seen.im     = req_ch.imag_part;
         predict_list_op(seen);
         req_transfers++;
      end
   end

   task automatic add_request(action_type act, part_type re, part_type im);
      list_request_type r;
      r.action = act;
      r.re     = re;
      r.im     = im;
      pending_requests.push_back(r);
   endtask

   // parts lean on the extremes and on small values so ties show up
   function automatic part_type random_part();
      case ($urandom_range(4))
         0:       return part_type'(-32768);
         1:       return part_type'(32767);
         2:       return part_type'(int'($urandom_range(16)) - 8);
         default: return part_type'($urandom);
      endcase
   endfunction

   task automatic add_random_requests(int n);
      for (int i = 0; i < n; i++)
         add_request(($urandom_range(99) < 30) ? ACT_DUMP : ACT_INSERT,
                     random_part(), random_part());
   endtask

   // sender holds back until everything queued went out and every result came home
   task automatic wait_for_drain();
      while (pending_requests.size() != 0 || req_offered != req_transfers ||
             expected_rsp.size() != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic run_random_phase(int n, int idle_pct, int stall_pct);
      sender_idle_pct = idle_pct;
      rsp_stall_pct   = stall_pct;
      add_random_requests(n);
      wait_for_drain();
   endtask

   initial begin : stimulus
      int start_count;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty dump, extremes, ties in magnitude, dumps in between
      add_request(ACT_DUMP,   part_type'(32767),  part_type'(-32768));
      add_request(ACT_INSERT, part_type'(0),      part_type'(0));
      add_request(ACT_INSERT, part_type'(-32768), part_type'(-32768));
      add_request(ACT_INSERT, part_type'(32767),  part_type'(32767));
      add_request(ACT_INSERT, part_type'(-32768), part_type'(0));
      add_request(ACT_INSERT, part_type'(0),      part_type'(-32768));
      add_request(ACT_INSERT, part_type'(3),      part_type'(4));
      add_request(ACT_INSERT, part_type'(-4),     part_type'(-3));
      add_request(ACT_DUMP,   part_type'(0),      part_type'(0));
      add_request(ACT_INSERT, part_type'(5),      part_type'(0));
      add_request(ACT_INSERT, part_type'(0),      part_type'(0));
      add_request(ACT_INSERT, part_type'(1),      part_type'(-1));
      add_request(ACT_DUMP,   part_type'(-1),     part_type'(1));
      wait_for_drain();

      // random phases: fill the list up, then full drops and long dumps
      run_random_phase(30, 0, 0);
      run_random_phase(30, 73, 0);
      run_random_phase(30, 0, 73);
      run_random_phase(30, 34, 34);

      // pressure: sender keeps offering while the receiver holds off
      sender_idle_pct = 0;
      rsp_stall_pct   = 0;
      add_random_requests(35);
      add_request(ACT_DUMP, random_part(), random_part());
      start_count = req_transfers;
      while (req_transfers < start_count + 2) @(posedge clock);
      holdoff_requests++;
      wait_for_drain();

      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // hard stop if the block hangs
   initial begin : watchdog
      #2ms;
      $display("tb: failure");
      $finish;
   end

endmodule

### magnitude_sorted_insert_list.f
hdl/msil_pkg.sv
hdl/msil_if.sv
hdl/msil_front.sv
hdl/msil_queue.sv
hdl/msil_back.sv
hdl/magnitude_sorted_insert_list.sv
hdl/msil_checker.sv
tb/testbench.sv
